// File: rtl/vas_pkg.sv
// shared types, codes and widths for the voice allocator
// no dependencies; compiled first
package vas_pkg;

  localparam int NUM_VOICES_DEF = 16;
  localparam int MAX_VOICES     = 64;

  localparam int ACTION_W  = 3;
  localparam int NOTE_W    = 8;
  localparam int VEL_W     = 7;
  localparam int VOICE_W   = 4;
  localparam int OUTCOME_W = 4;
  localparam int COUNT_W   = 5;
  localparam int AGE_W     = 16;

  // sized for the largest table the parameter allows
  localparam int VIDX_W = $clog2(MAX_VOICES);
  localparam int CNT_W  = $clog2(MAX_VOICES + 1);

  localparam logic [NOTE_W-1:0]  PREVIEW_NOTE = 8'd128;
  localparam logic [AGE_W-1:0]   AGE_MAX      = '1;
  localparam logic [COUNT_W-1:0] COUNT_SAT    = '1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_READY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTRO_FROM_START = 1'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NOTE_ON        = 3'd0,
    ACT_NOTE_OFF       = 3'd1,
    ACT_ALL_OFF        = 3'd2,
    ACT_AGE_TICK       = 3'd3,
    ACT_VOICE_FINISHED = 3'd4
  } action_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_IGNORED   = 4'd0,
    OC_FREE      = 4'd1,
    OC_RETRIG    = 4'd2,
    OC_STOLE_REL = 4'd3,
    OC_STOLE_OLD = 4'd4,
    OC_RELEASED  = 4'd5,
    OC_ALL_OFF   = 4'd6,
    OC_AGED      = 4'd7,
    OC_FREED     = 4'd8
  } outcome_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_CLEAR_START,
    CMD_RELEASE,
    CMD_CLEAR,
    CMD_AGE,
    CMD_FREE
  } cmd_op_t;

  // broadcast from control to every cell; note and target double as
  // scan key and looked-up voice while no update is issued
  typedef struct packed {
    cmd_op_t             op;
    logic [VIDX_W-1:0]   target;
    logic [NOTE_W-1:0]   note;
  } cmd_t;

  // running scan record handed from cell to cell
  typedef struct packed {
    logic                match_v;
    logic [VIDX_W-1:0]   match_idx;
    logic                free_v;
    logic [VIDX_W-1:0]   free_idx;
    logic                rel_v;
    logic [VIDX_W-1:0]   rel_idx;
    logic [AGE_W-1:0]    rel_age;
    logic                old_v;
    logic [VIDX_W-1:0]   old_idx;
    logic [AGE_W-1:0]    old_age;
    logic [CNT_W-1:0]    count;
    logic                tgt_active;
  } acc_t;

  localparam acc_t ACC_INIT = '0;

endpackage

// File: rtl/vas_if.sv
// valid/ready channel interfaces for the voice allocator items
// depends on vas_pkg
interface vas_in_if;
  logic                        valid;
  logic                        ready;
  logic [vas_pkg::ACTION_W-1:0] action;
  logic [vas_pkg::NOTE_W-1:0]   note;
  logic [vas_pkg::VEL_W-1:0]    velocity;
  logic [vas_pkg::VOICE_W-1:0]  voice_index;

  modport source (output valid, action, note, velocity, voice_index, input ready);
  modport sink   (input valid, action, note, velocity, voice_index, output ready);
endinterface

interface vas_out_if;
  logic                          valid;
  logic                          ready;
  logic [vas_pkg::VOICE_W-1:0]   voice;
  logic [vas_pkg::OUTCOME_W-1:0] outcome;
  logic [vas_pkg::NOTE_W-1:0]    note_out;
  logic [vas_pkg::VEL_W-1:0]     velocity_out;
  logic                          intro_requested;
  logic [vas_pkg::COUNT_W-1:0]   active_count;
  logic                          any_playing;

  modport source (output valid, voice, outcome, note_out, velocity_out, intro_requested,
                  active_count, any_playing, input ready);
  modport sink   (input valid, voice, outcome, note_out, velocity_out, intro_requested,
                  active_count, any_playing, output ready);
endinterface

// File: rtl/voice_allocator_with_stealing_core.sv
// top level of the voice allocator: sequencer plus the chain of voice cells
// depends on vas_pkg, vas_if, vas_cell, vas_ctrl

// Polyphonic voice allocator. Each voice lives in its own cell of a chain;
// an item is taken on the input channel, then a scan record walks the chain
// one cell per clock, collecting the first voice holding the item's note,
// the lowest free voice, the oldest releasing voice, the oldest voice, the
// number of active voices and the state of the addressed voice. When the
// record leaves the last cell the sequencer picks the outcome and broadcasts
// one update to all cells in the same cycle the result item is registered.
// Items are handled one at a time, paced by the walk of the scan record
// through the chain. A finished result waits in the output register while
// the next item is already accepted and scanned.
// Configuration writes (source ready at index 0, intro mode at index 1)
// take effect at once and belong between items.
module voice_allocator_with_stealing_core #(
  parameter int NUM_VOICES = vas_pkg::NUM_VOICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  vas_in_if.sink                         in_ch,
  vas_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [vas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vas_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vas_pkg::*;

  // scan records between cells; link 0 is the empty record fed to the head
  acc_t link [NUM_VOICES+1];
  cmd_t cmd;

  assign link[0] = ACC_INIT;

  vas_ctrl #(
    .NUM_VOICES(NUM_VOICES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (link[NUM_VOICES]),
    .cmd       (cmd)
  );

  // one cell per voice, lowest index at the head so ties favor it
  for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
    vas_cell #(
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .acc_in  (link[i]),
      .acc_out (link[i+1])
    );
  end

endmodule

// File: rtl/vas_cell.sv
// one voice slot of the chain: holds the voice state, folds it into the
// scan record passed to the next cell; depends on vas_pkg
module vas_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  vas_pkg::cmd_t cmd,
  input  vas_pkg::acc_t acc_in,
  output vas_pkg::acc_t acc_out
);
  import vas_pkg::*;

  localparam logic [VIDX_W-1:0] MY_IDX = VIDX_W'(IDX);

  logic              active;
  logic              releasing;
  logic [NOTE_W-1:0] note;
  logic [AGE_W-1:0]  age;
  acc_t              acc_next;
  logic              hit;

  assign hit = (cmd.target == MY_IDX);

  always_comb begin
    acc_next = acc_in;
    if (!acc_in.match_v && active && note == cmd.note) begin
      acc_next.match_v   = 1'b1;
      acc_next.match_idx = MY_IDX;
    end
    if (!acc_in.free_v && !active) begin
      acc_next.free_v   = 1'b1;
      acc_next.free_idx = MY_IDX;
    end
    if (releasing && (!acc_in.rel_v || age > acc_in.rel_age)) begin
      acc_next.rel_v   = 1'b1;
      acc_next.rel_idx = MY_IDX;
      acc_next.rel_age = age;
    end
    if (!acc_in.old_v || age > acc_in.old_age) begin
      acc_next.old_v   = 1'b1;
      acc_next.old_idx = MY_IDX;
      acc_next.old_age = age;
    end
    acc_next.count = acc_in.count + CNT_W'(active);
    if (hit) begin
      acc_next.tgt_active = active;
    end
  end

  always_ff @(posedge clk) begin
    acc_out <= acc_next;
    if (rst) begin
      active    <= 1'b0;
      releasing <= 1'b0;
      age       <= '0;
    end else begin
      unique case (cmd.op)
        CMD_START: begin
          if (hit) begin
            active    <= 1'b1;
            releasing <= 1'b0;
            note      <= cmd.note;
            age       <= '0;
          end
        end
        CMD_CLEAR_START: begin
          active    <= hit;
          releasing <= 1'b0;
          if (hit) begin
            note <= cmd.note;
            age  <= '0;
          end
        end
        CMD_RELEASE: begin
          if (hit) begin
            releasing <= 1'b1;
          end
        end
        CMD_CLEAR: begin
          active    <= 1'b0;
          releasing <= 1'b0;
        end
        CMD_AGE: begin
          if (active && age != AGE_MAX) begin
            age <= age + AGE_W'(1);
          end
        end
        CMD_FREE: begin
          if (hit) begin
            active    <= 1'b0;
            releasing <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/vas_ctrl.sv
// item sequencer: takes an item, waits for the scan to leave the chain,
// decides the outcome, issues the update and holds the result item
// depends on vas_pkg and vas_if
module vas_ctrl #(
  parameter int NUM_VOICES = vas_pkg::NUM_VOICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  vas_in_if.sink                            in_ch,
  vas_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [vas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vas_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  vas_pkg::acc_t                     acc,
  output vas_pkg::cmd_t                     cmd
);
  import vas_pkg::*;

  localparam int SCW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [SCW-1:0]    SCAN_LAST  = SCW'(NUM_VOICES - 1);
  localparam logic [VIDX_W:0]   NUM_V_WIDE = (VIDX_W + 1)'(NUM_VOICES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t              state;
  logic [SCW-1:0]      scan_cnt;
  logic                source_ready;
  logic                intro_from_start;

  logic [ACTION_W-1:0] item_action;
  logic [NOTE_W-1:0]   item_note;
  logic [VEL_W-1:0]    item_vel;
  logic [VOICE_W-1:0]  item_vidx;

  // decision of the apply cycle
  cmd_op_t             dec_op;
  logic [VIDX_W-1:0]   dec_voice;
  outcome_t            dec_outcome;
  logic                dec_start;
  logic                dec_intro;
  logic [CNT_W-1:0]    dec_count;
  logic                intro_now;
  logic                fire;

  assign in_ch.ready = (state == ST_IDLE);
  assign fire        = (state == ST_APPLY) && (!out_ch.valid || out_ch.ready);
  assign intro_now   = (item_note != PREVIEW_NOTE) && intro_from_start;

  always_comb begin
    dec_op      = CMD_NONE;
    dec_voice   = '0;
    dec_outcome = OC_IGNORED;
    dec_start   = 1'b0;
    dec_intro   = 1'b0;
    dec_count   = acc.count;
    unique case (action_t'(item_action))
      ACT_NOTE_ON: begin
        if (source_ready) begin
          dec_start = 1'b1;
          priority if (intro_now) begin
            dec_op      = CMD_CLEAR_START;
            dec_outcome = OC_FREE;
            dec_intro   = 1'b1;
            dec_count   = CNT_W'(1);
          end else if (acc.match_v) begin
            dec_op      = CMD_START;
            dec_voice   = acc.match_idx;
            dec_outcome = OC_RETRIG;
          end else if (acc.free_v) begin
            dec_op      = CMD_START;
            dec_voice   = acc.free_idx;
            dec_outcome = OC_FREE;
            dec_count   = acc.count + CNT_W'(1);
          end else if (acc.rel_v) begin
            dec_op      = CMD_START;
            dec_voice   = acc.rel_idx;
            dec_outcome = OC_STOLE_REL;
          end else begin
            dec_op      = CMD_START;
            dec_voice   = acc.old_idx;
            dec_outcome = OC_STOLE_OLD;
          end
        end
      end
      ACT_NOTE_OFF: begin
        if (acc.match_v) begin
          dec_op      = CMD_RELEASE;
          dec_voice   = acc.match_idx;
          dec_outcome = OC_RELEASED;
        end
      end
      ACT_ALL_OFF: begin
        dec_op      = CMD_CLEAR;
        dec_outcome = OC_ALL_OFF;
        dec_count   = '0;
      end
      ACT_AGE_TICK: begin
        dec_op      = CMD_AGE;
        dec_outcome = OC_AGED;
      end
      ACT_VOICE_FINISHED: begin
        if ((VIDX_W + 1)'(item_vidx) < NUM_V_WIDE) begin
          dec_op      = CMD_FREE;
          dec_voice   = VIDX_W'(item_vidx);
          dec_outcome = OC_FREED;
          dec_count   = acc.count - CNT_W'(acc.tgt_active);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.note   = item_note;
    cmd.target = (state == ST_APPLY) ? dec_voice : VIDX_W'(item_vidx);
    cmd.op     = fire ? dec_op : CMD_NONE;
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_action <= in_ch.action;
      item_note   <= in_ch.note;
      item_vel    <= in_ch.velocity;
      item_vidx   <= in_ch.voice_index;
    end
    if (fire) begin
      out_ch.voice           <= dec_voice[VOICE_W-1:0];
      out_ch.outcome         <= dec_outcome;
      out_ch.note_out        <= dec_start ? item_note : '0;
      out_ch.velocity_out    <= dec_start ? item_vel : '0;
      out_ch.intro_requested <= dec_intro;
      out_ch.active_count    <= (dec_count > CNT_W'(COUNT_SAT)) ? COUNT_SAT
                                                                : dec_count[COUNT_W-1:0];
      out_ch.any_playing     <= (dec_count != '0);
    end
    if (rst) begin
      state            <= ST_IDLE;
      scan_cnt         <= '0;
      out_ch.valid     <= 1'b0;
      source_ready     <= 1'b0;
      intro_from_start <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SOURCE_READY:     source_ready     <= cfg_data[0];
          CFG_INTRO_FROM_START: intro_from_start <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (fire) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_cnt == SCAN_LAST) begin
            state <= ST_APPLY;
          end else begin
            scan_cnt <= scan_cnt + SCW'(1);
          end
        end
        ST_APPLY: begin
          if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/vas_checker.sv
// port-level checks on the voice allocator result channel, bound to the top
// depends on vas_pkg and voice_allocator_with_stealing_core
module vas_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [vas_pkg::VOICE_W-1:0]   voice,
  input logic [vas_pkg::OUTCOME_W-1:0] outcome,
  input logic [vas_pkg::NOTE_W-1:0]    note_out,
  input logic [vas_pkg::VEL_W-1:0]     velocity_out,
  input logic                          intro_requested,
  input logic [vas_pkg::COUNT_W-1:0]   active_count,
  input logic                          any_playing
);
  import vas_pkg::*;

  logic starts;
  assign starts = (outcome == OC_FREE) || (outcome == OC_RETRIG) ||
                  (outcome == OC_STOLE_REL) || (outcome == OC_STOLE_OLD);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(voice)
      && $stable(active_count))
    else $error("result changed while stalled");

  a_playing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> any_playing == (active_count != '0))
    else $error("any_playing disagrees with active_count");

  a_no_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !starts |-> note_out == '0 && velocity_out == '0 && !intro_requested)
    else $error("start fields set without a started voice");

  a_intro: assert property (@(posedge clk) disable iff (rst)
    out_valid && intro_requested |-> outcome == OC_FREE && voice == '0
      && active_count == COUNT_W'(1))
    else $error("intro start not on voice zero alone");

  a_all_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OC_ALL_OFF |-> active_count == '0 && !any_playing)
    else $error("voices left active after all-off");

endmodule

bind voice_allocator_with_stealing_core vas_checker u_vas_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .voice           (out_ch.voice),
  .outcome         (out_ch.outcome),
  .note_out        (out_ch.note_out),
  .velocity_out    (out_ch.velocity_out),
  .intro_requested (out_ch.intro_requested),
  .active_count    (out_ch.active_count),
  .any_playing     (out_ch.any_playing)
);

// File: bench/tb_top.sv
// self-checking bench for voice_allocator_with_stealing_core: directed and random
// voice events against an in-bench model of the voice table
// depends on vas_pkg and the vas_in_if / vas_out_if interfaces
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vas_pkg::*;

  localparam int NV          = NUM_VOICES_DEF;
  localparam int LATENCY     = NV + 2;
  localparam int IDLE_PCT    = 37;
  localparam int NO_VOICE    = -1;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // action codes the block must ignore
  localparam logic [ACTION_W-1:0] ACT_RESERVED_LO  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RESERVED_MID = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RESERVED_HI  = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [NOTE_W-1:0]   note;
    logic [VEL_W-1:0]    velocity;
    logic [VOICE_W-1:0]  voice_index;
  } voice_cmd_t;

  typedef struct packed {
    logic [VOICE_W-1:0]   voice;
    logic [OUTCOME_W-1:0] outcome;
    logic [NOTE_W-1:0]    note_out;
    logic [VEL_W-1:0]     velocity_out;
    logic                 intro_requested;
    logic [COUNT_W-1:0]   active_count;
    logic                 any_playing;
  } voice_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vas_in_if  in_ch ();
  vas_out_if out_ch ();

  voice_allocator_with_stealing_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // items waiting to be offered, and results the voice table model predicts
  voice_cmd_t pending_cmds[$];
  voice_res_t expected_results[$];

  // model copy of the voice table and the two mode bits
  bit                 tbl_active[NV];
  bit [NOTE_W-1:0]    tbl_note[NV];
  bit                 tbl_releasing[NV];
  bit [AGE_W-1:0]     tbl_age[NV];
  bit                 mirror_source_ready;
  bit                 mirror_intro;

  int          mismatches = 0;
  int unsigned cycle_cnt  = 0;
  bit          cmd_taken  = 1'b0;  // set at the edge an item is accepted
  bit          calm       = 1'b0;  // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // first active voice holding the note, or none
  function automatic int find_note(logic [NOTE_W-1:0] n);
    for (int i = 0; i < NV; i++)
      if (tbl_active[i] && tbl_note[i] == n) return i;
    return NO_VOICE;
  endfunction

  // apply one event to the voice table model and return the result it must give
  function automatic voice_res_t apply_to_voice_table(voice_cmd_t c);
    voice_res_t  r;
    int          v;
    int          best_age;
    int unsigned cnt;
    bit          intro_now;
    r = '0;
    cnt = 0;
    intro_now = 1'b0;
    case (c.action)
      ACT_NOTE_ON: begin
        // a note-on is dropped entirely while no source is loaded
        if (mirror_source_ready) begin
          intro_now = (c.note != PREVIEW_NOTE) && mirror_intro;
          // intro mode: a real note wipes the table before the search
          if (intro_now) begin
            for (int i = 0; i < NV; i++) begin
              tbl_active[i] = 1'b0;
              tbl_releasing[i] = 1'b0;
            end
          end
          v = find_note(c.note);
          if (v != NO_VOICE) begin
            r.outcome = OC_RETRIG;
          end else begin
            // lowest free voice
            for (int i = NV - 1; i >= 0; i--)
              if (!tbl_active[i]) v = i;
            if (v != NO_VOICE) begin
              r.outcome = OC_FREE;
            end else begin
              // oldest releasing voice, lowest index on a tie
              best_age = -1;
              for (int i = 0; i < NV; i++)
                if (tbl_releasing[i] && int'(tbl_age[i]) > best_age) begin
                  v = i;
                  best_age = int'(tbl_age[i]);
                end
              if (v != NO_VOICE) begin
                r.outcome = OC_STOLE_REL;
              end else begin
                // oldest voice of all
                v = 0;
                best_age = -1;
                for (int i = 0; i < NV; i++)
                  if (int'(tbl_age[i]) > best_age) begin
                    v = i;
                    best_age = int'(tbl_age[i]);
                  end
                r.outcome = OC_STOLE_OLD;
              end
            end
          end
          tbl_active[v] = 1'b1;
          tbl_note[v] = c.note;
          tbl_releasing[v] = 1'b0;
          tbl_age[v] = '0;
          r.voice = VOICE_W'(v);
          r.note_out = c.note;
          r.velocity_out = c.velocity;
          r.intro_requested = intro_now;
        end
      end
      ACT_NOTE_OFF: begin
        // an already releasing voice is reported as released again
        v = find_note(c.note);
        if (v != NO_VOICE) begin
          tbl_releasing[v] = 1'b1;
          r.voice = VOICE_W'(v);
          r.outcome = OC_RELEASED;
        end
      end
      ACT_ALL_OFF: begin
        for (int i = 0; i < NV; i++) begin
          tbl_active[i] = 1'b0;
          tbl_releasing[i] = 1'b0;
        end
        r.outcome = OC_ALL_OFF;
      end
      ACT_AGE_TICK: begin
        // ages stick at the top value
        for (int i = 0; i < NV; i++)
          if (tbl_active[i] && tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + AGE_W'(1);
        r.outcome = OC_AGED;
      end
      ACT_VOICE_FINISHED: begin
        // freeing an idle voice is still reported as freed
        if (int'(c.voice_index) < NV) begin
          tbl_active[c.voice_index] = 1'b0;
          tbl_releasing[c.voice_index] = 1'b0;
          r.voice = c.voice_index;
          r.outcome = OC_FREED;
        end
      end
      default: begin
        // reserved actions leave everything alone
      end
    endcase
    for (int i = 0; i < NV; i++)
      if (tbl_active[i]) cnt++;
    r.active_count = (cnt > COUNT_SAT) ? COUNT_SAT : COUNT_W'(cnt);
    r.any_playing = (cnt != 0);
    return r;
  endfunction

  task automatic check_result(voice_res_t got, voice_res_t want);
    int unsigned g[7];
    int unsigned w[7];
    string names[7];
    names = '{"voice", "outcome", "note_out", "velocity_out", "intro_requested",
              "active_count", "any_playing"};
    g = '{got.voice, got.outcome, got.note_out, got.velocity_out, got.intro_requested,
          got.active_count, got.any_playing};
    w = '{want.voice, want.outcome, want.note_out, want.velocity_out, want.intro_requested,
          want.active_count, want.any_playing};
    for (int i = 0; i < 7; i++)
      if (g[i] != w[i])
        report_mismatch($sformatf("%s got %0d, expected %0d", names[i], g[i], w[i]));
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers the oldest pending item at the falling edge; a valid item
  // is held until the block takes it, then the next one goes out or a gap
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || cmd_taken) begin
      cmd_taken = 1'b0;
      if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_ch.valid       <= 1'b1;
        in_ch.action      <= pending_cmds[0].action;
        in_ch.note        <= pending_cmds[0].note;
        in_ch.velocity    <= pending_cmds[0].velocity;
        in_ch.voice_index <= pending_cmds[0].voice_index;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side backpressure, also changed at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: at the rising edge, mirror register writes, predict each accepted
  // item and compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    voice_cmd_t c;
    voice_res_t got;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE_READY:     mirror_source_ready = cfg_data[0];
          CFG_INTRO_FROM_START: mirror_intro = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        c.action      = in_ch.action;
        c.note        = in_ch.note;
        c.velocity    = in_ch.velocity;
        c.voice_index = in_ch.voice_index;
        void'(pending_cmds.pop_front());
        expected_results.push_back(apply_to_voice_table(c));
        cmd_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.voice           = out_ch.voice;
        got.outcome         = out_ch.outcome;
        got.note_out        = out_ch.note_out;
        got.velocity_out    = out_ch.velocity_out;
        got.intro_requested = out_ch.intro_requested;
        got.active_count    = out_ch.active_count;
        got.any_playing     = out_ch.any_playing;
        if (expected_results.size() == 0)
          report_mismatch("result item with no item outstanding");
        else
          check_result(got, expected_results.pop_front());
      end
    end
  end

  // watchdog on a plain cycle count
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d items still pending, %0d results outstanding",
             cycle_cnt, pending_cmds.size(), expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(logic [ACTION_W-1:0] a, logic [NOTE_W-1:0] n,
                           logic [VEL_W-1:0] vel, logic [VOICE_W-1:0] idx);
    voice_cmd_t c;
    c.action = a;
    c.note = n;
    c.velocity = vel;
    c.voice_index = idx;
    pending_cmds.push_back(c);
  endtask

  // sender holds off until every item has been answered; one item always
  // gives one result, so the block is idle once the queues run dry
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_mode(bit src, bit intro);
    wait_idle();
    write_reg(CFG_SOURCE_READY, src);
    write_reg(CFG_INTRO_FROM_START, intro);
  endtask

  // random voice traffic: mostly notes from a narrow band so that note-offs
  // and retriggers hit, enough note-ons to fill the table and force steals,
  // plus some full-range notes, all-offs and reserved actions as noise
  task automatic run_random(int n);
    voice_cmd_t  c;
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      c.velocity = VEL_W'($urandom_range(127));
      c.voice_index = VOICE_W'($urandom_range(NV - 1));
      c.note = ($urandom_range(99) < 80) ? NOTE_W'($urandom_range(79, 60))
                                         : NOTE_W'($urandom_range(PREVIEW_NOTE));
      if (pick < 46)      c.action = ACT_NOTE_ON;
      else if (pick < 64) c.action = ACT_NOTE_OFF;
      else if (pick < 84) c.action = ACT_AGE_TICK;
      else if (pick < 94) c.action = ACT_VOICE_FINISHED;
      else if (pick < 96) c.action = ACT_ALL_OFF;
      else                c.action = ACTION_W'($urandom_range(ACT_RESERVED_HI,
                                                              ACT_RESERVED_LO));
      pending_cmds.push_back(c);
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // every input known from time zero
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SOURCE_READY;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_NOTE_ON;
    in_ch.note = '0;
    in_ch.velocity = '0;
    in_ch.voice_index = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: source not loaded yet, so the note-on is ignored
    queue_cmd(ACT_NOTE_ON, 8'd60, 7'd64, 4'd0);
    set_mode(1'b1, 1'b0);
    queue_cmd(ACT_NOTE_ON, 8'd0, 7'd0, 4'd0);            // lowest note, lowest velocity
    queue_cmd(ACT_NOTE_ON, 8'd127, 7'd127, 4'd15);       // highest note, highest velocity
    queue_cmd(ACT_NOTE_ON, PREVIEW_NOTE, 7'd85, 4'd0);   // preview note takes a voice
    queue_cmd(ACT_NOTE_ON, 8'd0, 7'd42, 4'd0);           // same note again: retrigger
    queue_cmd(ACT_NOTE_OFF, 8'd127, 7'd0, 4'd0);         // release
    queue_cmd(ACT_NOTE_OFF, 8'd127, 7'd0, 4'd0);         // released voice released again
    queue_cmd(ACT_NOTE_OFF, 8'd55, 7'd0, 4'd0);          // no voice holds it
    queue_cmd(ACT_AGE_TICK, 8'd0, 7'd0, 4'd0);
    queue_cmd(ACT_NOTE_ON, 8'd127, 7'd9, 4'd0);          // retrigger of a releasing voice
    queue_cmd(ACT_VOICE_FINISHED, 8'd0, 7'd0, 4'd15);    // idle voice still reported freed
    queue_cmd(ACT_VOICE_FINISHED, 8'd0, 7'd0, 4'd2);
    queue_cmd(ACT_RESERVED_LO, PREVIEW_NOTE, 7'd127, 4'd15);
    queue_cmd(ACT_RESERVED_MID, 8'd0, 7'd0, 4'd0);
    queue_cmd(ACT_RESERVED_HI, 8'd127, 7'd127, 4'd15);
    queue_cmd(ACT_ALL_OFF, 8'd0, 7'd0, 4'd0);
    queue_cmd(ACT_NOTE_OFF, 8'd0, 7'd0, 4'd0);           // nothing left to release
    set_mode(1'b1, 1'b1);
    queue_cmd(ACT_NOTE_ON, 8'd40, 7'd100, 4'd0);         // intro: clear, voice 0, intro flag
    queue_cmd(ACT_NOTE_ON, PREVIEW_NOTE, 7'd1, 4'd0);    // preview: no clear, no intro
    queue_cmd(ACT_NOTE_ON, 8'd41, 7'd2, 4'd0);           // clears the preview voice too
    queue_cmd(ACT_NOTE_ON, 8'd41, 7'd3, 4'd0);           // cleared first, so not a retrigger
    set_mode(1'b0, 1'b1);
    queue_cmd(ACT_NOTE_ON, 8'd40, 7'd100, 4'd0);         // ignored despite intro mode

    // random phases across the register settings
    set_mode(1'b1, 1'b0);
    run_random(550);
    calm = 1'b1;                                         // stretch with no idling
    run_random(300);
    calm = 1'b0;
    set_mode(1'b0, 1'b1);
    run_random(100);
    set_mode(1'b1, 1'b1);
    run_random(300);
    set_mode(1'b0, 1'b0);
    run_random(50);
    set_mode(1'b1, 1'b0);
    run_random(200);

    // stealing: fill the table, restart voice 0 late so voices 1 to 15 tie
    // as oldest; the steal takes voice 1, then a released voice is preferred
    calm = 1'b1;
    queue_cmd(ACT_ALL_OFF, 8'd0, 7'd0, 4'd0);
    for (int k = 0; k < NV; k++)
      queue_cmd(ACT_NOTE_ON, NOTE_W'(10 + k), VEL_W'(k), 4'd0);
    queue_cmd(ACT_VOICE_FINISHED, 8'd0, 7'd0, 4'd0);
    repeat (5) queue_cmd(ACT_AGE_TICK, 8'd0, 7'd0, 4'd0);
    queue_cmd(ACT_NOTE_ON, 8'd30, 7'd30, 4'd0);
    repeat (2) queue_cmd(ACT_AGE_TICK, 8'd0, 7'd0, 4'd0);
    queue_cmd(ACT_NOTE_ON, 8'd31, 7'd31, 4'd0);          // steals oldest, lowest on the tie
    queue_cmd(ACT_NOTE_OFF, 8'd12, 7'd0, 4'd0);
    queue_cmd(ACT_NOTE_ON, 8'd32, 7'd32, 4'd0);          // steals the releasing voice
    wait_idle();
    calm = 1'b0;

    // let any stray result show up before the verdict
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/vas_pkg.sv
rtl/vas_if.sv
rtl/vas_cell.sv
rtl/vas_ctrl.sv
rtl/voice_allocator_with_stealing_core.sv
rtl/vas_checker.sv
bench/tb_top.sv
